[hw/rtl/dsq_pkg.sv]
package dsq_pkg;

   localparam int LETTER_W      = 5;
   localparam int CHAR_W        = 7;
   localparam int BYTE_W        = 8;
   localparam int CELL_COUNT    = 25;
   localparam int CELLS_PER_ROW = 5;
   localparam int ROW_W         = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 60;
   localparam int BEAT_W        = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_LO  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_MID = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_LAST = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILLER    = 2'd3;

   localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_Z     = 5'd25;
   localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

   localparam logic [BYTE_W-1:0] BYTE_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] BYTE_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] BYTE_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] BYTE_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_Z = 7'h5A;

   localparam logic [ROW_W-1:0] LAST_ROW = 3'd4;

   typedef logic [CELL_COUNT-1:0][LETTER_W-1:0] square_type;

   typedef struct packed {
      logic                valid;
      logic [LETTER_W-1:0] letter_a;
      logic [LETTER_W-1:0] letter_b;
      logic                twice;
      logic                last;
   } job_type;

   function automatic logic [LETTER_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                       input logic [ROW_W-1:0] col);
      cell_index = LETTER_W'(row) * LETTER_W'(CELLS_PER_ROW) + LETTER_W'(col);
   endfunction

   function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] pos);
      wrap_next = (pos == LAST_ROW) ? '0 : pos + 3'd1;
   endfunction

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [LETTER_W-1:0] v);
      to_ascii = (v > LETTER_Z) ? CHAR_Z : CHAR_A + CHAR_W'(v);
   endfunction

endpackage

[hw/rtl/dsq_front.sv]
module dsq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dsq_pkg::BYTE_W-1:0]    req_text_byte,
   input  logic                          req_end_of_text,
   input  logic [dsq_pkg::LETTER_W-1:0]  filler,
   input  logic                          job_take,
   output dsq_pkg::job_type              job
);
   import dsq_pkg::*;

   logic [LETTER_W-1:0] held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   logic                job_valid_ff, job_valid_in;
   job_type             job_data_ff, job_data_in;
   logic                accept;
   logic [BYTE_W-1:0]   upper;
   logic                is_letter;
   logic [LETTER_W-1:0] letter;
   logic                pair_now;
   logic                pair_end;

   assign req_stall = job_valid_ff && !job_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      upper = req_text_byte;
      if (req_text_byte inside {[BYTE_LOWER_A:BYTE_LOWER_Z]}) begin
         upper = req_text_byte - CASE_OFFSET;
      end
      is_letter = upper inside {[BYTE_UPPER_A:BYTE_UPPER_Z]};
      letter    = LETTER_W'(upper - BYTE_UPPER_A);
      if (letter == LETTER_J) begin
         letter = LETTER_I;
      end
   end

   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      pair_now      = 1'b0;
      job_data_in   = '0;
      job_data_in.letter_a = held_ff;
      job_data_in.letter_b = filler;
      if (is_letter) begin
         if (!held_valid_ff) begin
            held_in       = letter;
            held_valid_in = 1'b1;
            job_data_in.letter_a = letter;
         end else if (held_ff == letter) begin
            pair_now = 1'b1;
         end else begin
            pair_now             = 1'b1;
            job_data_in.letter_b = letter;
            held_valid_in        = 1'b0;
         end
      end
      pair_end = req_end_of_text && held_valid_in;
      if (req_end_of_text) begin
         held_valid_in = 1'b0;
      end
      job_data_in.valid = pair_now || pair_end;
      job_data_in.twice = pair_now && pair_end;
      job_data_in.last  = req_end_of_text;
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      if (accept) begin
         job_valid_in = job_data_in.valid;
      end else if (job_take) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_data_ff <= job_data_in;
      end
   end

   always_comb begin
      job       = job_data_ff;
      job.valid = job_valid_ff;
   end

   held_not_j: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> held_ff != LETTER_J)
      else $error("pending letter holds J");

   twice_needs_end: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && job_data_ff.twice |-> job_data_ff.last)
      else $error("repeated pair outside the final transfer");

   job_a_not_j: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> job_data_ff.letter_a != LETTER_J)
      else $error("digraph starts with J");

endmodule

[hw/rtl/dsq_pair_cipher.sv]
module dsq_pair_cipher (
   input  dsq_pkg::square_type           square,
   input  logic [dsq_pkg::LETTER_W-1:0]  letter_a,
   input  logic [dsq_pkg::LETTER_W-1:0]  letter_b,
   output logic [dsq_pkg::CHAR_W-1:0]    char_a,
   output logic [dsq_pkg::CHAR_W-1:0]    char_b
);
   import dsq_pkg::*;

   logic [ROW_W-1:0] row_a, col_a, row_b, col_b;
   logic [ROW_W-1:0] out_row_a, out_col_a, out_row_b, out_col_b;

   always_comb begin
      row_a = '0;
      col_a = '0;
      row_b = '0;
      col_b = '0;
      for (int n = 0; n < CELL_COUNT; n++) begin
         if (square[n] == letter_a) begin
            row_a = ROW_W'(n / CELLS_PER_ROW);
            col_a = ROW_W'(n % CELLS_PER_ROW);
         end
         if (square[n] == letter_b) begin
            row_b = ROW_W'(n / CELLS_PER_ROW);
            col_b = ROW_W'(n % CELLS_PER_ROW);
         end
      end
   end

   always_comb begin
      if (row_a == row_b) begin
         out_row_a = row_a;
         out_col_a = wrap_next(col_a);
         out_row_b = row_b;
         out_col_b = wrap_next(col_b);
      end else if (col_a == col_b) begin
         out_row_a = wrap_next(row_a);
         out_col_a = col_a;
         out_row_b = wrap_next(row_b);
         out_col_b = col_b;
      end else begin
         out_row_a = row_a;
         out_col_a = col_b;
         out_row_b = row_b;
         out_col_b = col_a;
      end
   end

   assign char_a = to_ascii(square[cell_index(out_row_a, out_col_a)]);
   assign char_b = to_ascii(square[cell_index(out_row_b, out_col_b)]);

endmodule

[hw/rtl/dsq_emit.sv]
module dsq_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  dsq_pkg::job_type              job,
   input  logic [dsq_pkg::CHAR_W-1:0]    char_a,
   input  logic [dsq_pkg::CHAR_W-1:0]    char_b,
   output logic                          job_take,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsq_pkg::CHAR_W-1:0]    rsp_cipher_char,
   output logic                          rsp_last_of_text
);
   import dsq_pkg::*;

   logic                valid_ff;
   logic [CHAR_W-1:0]   char_a_ff, char_b_ff;
   logic                twice_ff, last_ff;
   logic [BEAT_W-1:0]   beat_ff, beat_in;
   logic [BEAT_W-1:0]   final_beat;
   logic                out_accept;
   logic                load;

   assign final_beat = twice_ff ? 2'd3 : 2'd1;
   assign out_accept = valid_ff && !rsp_stall;
   assign job_take   = !valid_ff || (out_accept && beat_ff == final_beat);
   assign load       = job_take && job.valid;

   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = '0;
      end else if (out_accept) begin
         beat_in = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         if (job_take) begin
            valid_ff <= job.valid;
         end
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_a_ff <= char_a;
         char_b_ff <= char_b;
         twice_ff  <= job.twice;
         last_ff   <= job.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_cipher_char  = beat_ff[0] ? char_b_ff : char_a_ff;
   assign rsp_last_of_text = valid_ff && last_ff && (beat_ff == final_beat);

   single_pair_beats: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !twice_ff |-> beat_ff[1] == 1'b0)
      else $error("beat count runs past a single digraph");

   char_is_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cipher_char >= CHAR_A && rsp_cipher_char <= CHAR_Z)
      else $error("ciphertext character is not an uppercase letter");

   last_ends_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_text && !rsp_stall |-> job_take)
      else $error("final letter does not release the buffer");

endmodule

[hw/rtl/digraph_square_cipher_encrypt.sv]
// Playfair encryptor with a software-loaded 5x5 key square. Plaintext bytes enter one per
// transfer; letters are uppercased, J folds to I and everything else is dropped. A byte
// that closes a digraph or ends the text with a letter pending yields two ciphertext
// letters, a doubled letter at end of text yields four, and any other byte yields none.
// The output register sends one letter per cycle while rsp_stall is low. New bytes are
// taken while letters are still being sent if the front's job register is free or being
// emptied; a pair's first letter passes through that register, then the output register.
// The key square and filler letter must only be written while the block is idle.
module digraph_square_cipher_encrypt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [dsq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dsq_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dsq_pkg::BYTE_W-1:0]       req_text_byte,
   input  logic                             req_end_of_text,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dsq_pkg::CHAR_W-1:0]       rsp_cipher_char,
   output logic                             rsp_last_of_text
);
   import dsq_pkg::*;

   logic [CSR_DATA_W-1:0] cells_lo_ff, cells_mid_ff;
   logic [LETTER_W-1:0]   cell_last_ff, filler_ff;
   square_type            square;
   job_type               job;
   logic                  job_take;
   logic [CHAR_W-1:0]     char_a, char_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_lo_ff  <= '0;
         cells_mid_ff <= '0;
         cell_last_ff <= '0;
         filler_ff    <= FILLER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CELLS_LO:  cells_lo_ff  <= csr_write_data;
            CSR_CELLS_MID: cells_mid_ff <= csr_write_data;
            CSR_CELL_LAST: cell_last_ff <= csr_write_data[LETTER_W-1:0];
            CSR_FILLER:    filler_ff    <= csr_write_data[LETTER_W-1:0];
            default: ;
         endcase
      end
   end

   assign square = {cell_last_ff, cells_mid_ff, cells_lo_ff};

   dsq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .filler          (filler_ff),
      .job_take        (job_take),
      .job             (job)
   );

   dsq_pair_cipher u_pair_cipher (
      .square   (square),
      .letter_a (job.letter_a),
      .letter_b (job.letter_b),
      .char_a   (char_a),
      .char_b   (char_b)
   );

   dsq_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .job              (job),
      .char_a           (char_a),
      .char_b           (char_b),
      .job_take         (job_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_char  (rsp_cipher_char),
      .rsp_last_of_text (rsp_last_of_text)
   );

endmodule
